>>> design/lobm_pkg.sv
// Shared types, codes and constants of the limit order book matcher.
package lobm_pkg;

  localparam int DEFAULT_MAX_ORDERS = 32;
  localparam int TRADE_LIMIT = 63;
  localparam int TRADE_W = $clog2(TRADE_LIMIT + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  localparam logic SIDE_BUY = 1'b0;

  localparam logic RK_TRADE   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] order_id;
    logic        side;
    logic [19:0] price;
    logic [23:0] shares;
  } event_t;

  typedef struct packed {
    logic        report_kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [23:0] fill_qty;
    logic [19:0] fill_price;
    logic [23:0] rest_qty;
    logic [2:0]  status;
    logic        last;
  } report_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_best;
    logic       set_status;
    logic [2:0] status_code;
    logic       inval_k;
    logic       take_k_side;
    logic       shrink_k;
    logic       fill;
    logic       rest;
    logic       emit_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scan_done;
    logic       found;
    logic       shares_zero;
    logic       reprice;
    logic       match_ok;
    logic       qty_zero;
    logic       trade_limit;
  } dp_stat_t;

endpackage

>>> design/lobm_dp.sv
// Datapath: order table memory, valid bits, table scan and result register.
module lobm_dp #(
  parameter int MAX_ORDERS = lobm_pkg::DEFAULT_MAX_ORDERS
) (
  input  logic               clk,
  input  logic               rst,
  input  lobm_pkg::event_t   req,
  input  lobm_pkg::dp_cmd_t  cmd,
  output lobm_pkg::dp_stat_t stat,
  output lobm_pkg::report_t  report,
  output logic               report_valid
);

  localparam int IW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int TW = lobm_pkg::TRADE_W;

  logic [31:0] mem_id    [MAX_ORDERS];
  logic        mem_side  [MAX_ORDERS];
  logic [19:0] mem_price [MAX_ORDERS];
  logic [23:0] mem_qty   [MAX_ORDERS];
  logic [31:0] mem_arr   [MAX_ORDERS];

  lobm_pkg::event_t ev;
  logic            cur_side;
  logic [23:0]     cur_qty;
  logic            found;
  logic [IW-1:0]   k_idx;
  logic            k_side;
  logic [19:0]     k_price;
  logic [23:0]     k_qty;
  logic            free_ok;
  logic [IW-1:0]   free_idx;
  logic            best_ok;
  logic [IW-1:0]   best_idx;
  logic [19:0]     best_price;
  logic [23:0]     best_qty;
  logic [31:0]     best_id;
  logic [31:0]     best_age;
  logic [TW-1:0]   trades;
  logic [2:0]      status_r;
  logic [23:0]     rest_r;
  logic [31:0]     counter;
  logic [MAX_ORDERS-1:0] vbits;
  logic [CW-1:0]   scan_idx;
  logic            scanning;
  logic            scan_best_r;
  logic            pv;
  logic [IW-1:0]   pidx;
  logic [31:0]     r_id;
  logic            r_side;
  logic [19:0]     r_price;
  logic [23:0]     r_qty;
  logic [31:0]     r_arr;

  logic        issue;
  logic [31:0] age;
  logic        better;
  logic [23:0] fq;
  logic [23:0] rem;
  logic        we_qty;
  logic [IW-1:0] wq_addr;
  logic [23:0] wq_data;
  logic        we_full;

  assign issue   = scanning && (scan_idx < CW'(MAX_ORDERS));
  assign age     = counter - r_arr;
  assign better  = (cur_side == lobm_pkg::SIDE_BUY)
                 ? (r_price < best_price || (r_price == best_price && age > best_age))
                 : (r_price > best_price || (r_price == best_price && age > best_age));
  assign fq      = (cur_qty < best_qty) ? cur_qty : best_qty;
  assign rem     = best_qty - fq;
  assign we_qty  = cmd.shrink_k || cmd.fill;
  assign wq_addr = cmd.fill ? best_idx : k_idx;
  assign wq_data = cmd.fill ? rem : ev.shares;
  assign we_full = cmd.rest && (cur_qty != 24'd0) && free_ok;

  assign stat.kind        = ev.kind;
  assign stat.scan_done   = scanning && (scan_idx == CW'(MAX_ORDERS)) && !pv;
  assign stat.found       = found;
  assign stat.shares_zero = (ev.shares == 24'd0);
  assign stat.reprice     = (ev.price != k_price) || (ev.shares > k_qty);
  assign stat.match_ok    = best_ok && (best_price != 20'd0) &&
                            ((cur_side == lobm_pkg::SIDE_BUY) ? !(ev.price < best_price)
                                                              : !(ev.price > best_price));
  assign stat.qty_zero    = (cur_qty == 24'd0);
  assign stat.trade_limit = (trades == TW'(lobm_pkg::TRADE_LIMIT));

  always_ff @(posedge clk) begin
    if (issue) begin
      r_id    <= mem_id[scan_idx[IW-1:0]];
      r_side  <= mem_side[scan_idx[IW-1:0]];
      r_price <= mem_price[scan_idx[IW-1:0]];
      r_qty   <= mem_qty[scan_idx[IW-1:0]];
      r_arr   <= mem_arr[scan_idx[IW-1:0]];
    end
    if (we_qty) begin
      mem_qty[wq_addr] <= wq_data;
    end
    if (we_full) begin
      mem_id[free_idx]    <= ev.order_id;
      mem_side[free_idx]  <= cur_side;
      mem_price[free_idx] <= ev.price;
      mem_qty[free_idx]   <= cur_qty;
      mem_arr[free_idx]   <= counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning     <= 1'b0;
      pv           <= 1'b0;
      vbits        <= '0;
      counter      <= '0;
      report_valid <= 1'b0;
      found        <= 1'b0;
      free_ok      <= 1'b0;
      best_ok      <= 1'b0;
    end else begin
      report_valid <= cmd.fill || cmd.emit_sum;
      if (cmd.load) begin
        ev       <= req;
        cur_side <= req.side;
        cur_qty  <= req.shares;
        status_r <= lobm_pkg::ST_OK;
        rest_r   <= '0;
        trades   <= '0;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.scan_start) begin
        scanning    <= 1'b1;
        scan_idx    <= '0;
        scan_best_r <= cmd.scan_best;
        if (cmd.scan_best) begin
          best_ok <= 1'b0;
        end else begin
          found   <= 1'b0;
          free_ok <= 1'b0;
        end
      end else if (scanning) begin
        pv   <= issue;
        pidx <= scan_idx[IW-1:0];
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (stat.scan_done) begin
          scanning <= 1'b0;
        end
        if (pv) begin
          if (!scan_best_r) begin
            if (vbits[pidx] && r_id == ev.order_id && !found) begin
              found   <= 1'b1;
              k_idx   <= pidx;
              k_side  <= r_side;
              k_price <= r_price;
              k_qty   <= r_qty;
            end
            if (!vbits[pidx] && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= pidx;
            end
          end else if (vbits[pidx] && r_side != cur_side && (!best_ok || better)) begin
            best_ok    <= 1'b1;
            best_idx   <= pidx;
            best_price <= r_price;
            best_qty   <= r_qty;
            best_id    <= r_id;
            best_age   <= age;
          end
        end
      end
      if (cmd.take_k_side) begin
        cur_side <= k_side;
      end
      if (cmd.inval_k) begin
        vbits[k_idx] <= 1'b0;
        if (!free_ok || k_idx < free_idx) begin
          free_ok  <= 1'b1;
          free_idx <= k_idx;
        end
      end
      if (cmd.shrink_k) begin
        rest_r <= ev.shares;
      end
      if (cmd.fill) begin
        report.report_kind <= lobm_pkg::RK_TRADE;
        report.buyer_id    <= (cur_side == lobm_pkg::SIDE_BUY) ? ev.order_id : best_id;
        report.seller_id   <= (cur_side == lobm_pkg::SIDE_BUY) ? best_id : ev.order_id;
        report.fill_qty    <= fq;
        report.fill_price  <= (cur_side == lobm_pkg::SIDE_BUY) ? best_price : ev.price;
        report.rest_qty    <= '0;
        report.status      <= lobm_pkg::ST_OK;
        report.last        <= 1'b0;
        cur_qty <= cur_qty - fq;
        trades  <= trades + TW'(1);
        if (rem == 24'd0) begin
          vbits[best_idx] <= 1'b0;
          if (!free_ok || best_idx < free_idx) begin
            free_ok  <= 1'b1;
            free_idx <= best_idx;
          end
        end
      end
      if (cmd.rest && cur_qty != 24'd0) begin
        if (free_ok) begin
          vbits[free_idx] <= 1'b1;
          counter         <= counter + 32'd1;
          rest_r          <= cur_qty;
        end else begin
          status_r <= lobm_pkg::ST_FULL;
        end
      end
      if (cmd.emit_sum) begin
        report.report_kind <= lobm_pkg::RK_SUMMARY;
        report.buyer_id    <= '0;
        report.seller_id   <= '0;
        report.fill_qty    <= '0;
        report.fill_price  <= '0;
        report.rest_qty    <= rest_r;
        report.status      <= status_r;
        report.last        <= 1'b1;
      end
    end
  end

endmodule

>>> design/lobm_ctrl.sv
// Controller: event sequencing state machine.
module lobm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lobm_pkg::dp_stat_t stat,
  output lobm_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, FIND, DECIDE, MATCH, BEST, FILL, REST, SUM
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        if (stat.kind != lobm_pkg::KIND_ADD && stat.kind != lobm_pkg::KIND_CANCEL &&
            stat.kind != lobm_pkg::KIND_MODIFY) begin
          state_next = SUM;
        end else if (stat.kind == lobm_pkg::KIND_ADD && stat.shares_zero) begin
          cmd.set_status = 1'b1;
          cmd.status_code = lobm_pkg::ST_ZERO;
          state_next = SUM;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = FIND;
        end
      end
      FIND: begin
        if (stat.scan_done) state_next = DECIDE;
      end
      DECIDE: begin
        state_next = SUM;
        if (stat.kind == lobm_pkg::KIND_ADD) begin
          if (stat.found) begin
            cmd.set_status = 1'b1;
            cmd.status_code = lobm_pkg::ST_DUP;
          end else begin
            state_next = MATCH;
          end
        end else if (!stat.found) begin
          cmd.set_status = 1'b1;
          cmd.status_code = lobm_pkg::ST_UNKNOWN;
        end else if (stat.kind == lobm_pkg::KIND_CANCEL || stat.shares_zero) begin
          cmd.inval_k = 1'b1;
        end else if (stat.reprice) begin
          cmd.inval_k = 1'b1;
          cmd.take_k_side = 1'b1;
          state_next = MATCH;
        end else begin
          cmd.shrink_k = 1'b1;
        end
      end
      MATCH: begin
        if (stat.qty_zero || stat.trade_limit) begin
          state_next = REST;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_best = 1'b1;
          state_next = BEST;
        end
      end
      BEST: begin
        if (stat.scan_done) state_next = FILL;
      end
      FILL: begin
        if (stat.match_ok) begin
          cmd.fill = 1'b1;
          state_next = MATCH;
        end else begin
          state_next = REST;
        end
      end
      REST: begin
        cmd.rest = 1'b1;
        state_next = SUM;
      end
      SUM: begin
        cmd.emit_sum = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.scan_done |-> (state == FIND || state == BEST))
    else $error("scan completion outside a scan state");
  a_fill_needs_match: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> (!stat.qty_zero && !stat.trade_limit))
    else $error("fill issued with nothing to fill");
  a_sum_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sum |=> !busy)
    else $error("still busy after summary");

endmodule

>>> design/limit_order_book_matcher.sv
// Limit order book matcher top level: price-time priority over a resting order table.
// An event is taken when start is high and busy is low. busy stays high until the cycle in
// which the event's summary beat is on report; a new event can be taken at the edge that
// ends that cycle. Results appear on report for one cycle each, marked by report_valid,
// and cannot be held off: zero or more trade beats, then one summary beat with last set.
// Timing is set by the single table read port, which sweeps one entry per cycle. The id
// lookup is one full sweep of the table after acceptance, as is each scan for the best
// opposite order; an add, or a modify that reprices, runs one scan per fill and one more
// that finds nothing to match, unless the order fills completely or reaches the trade limit
// first. It then finishes through the REST and SUM states; SUM registers the summary beat.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = lobm_pkg::DEFAULT_MAX_ORDERS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lobm_pkg::event_t  req,
  output lobm_pkg::report_t report,
  output logic              report_valid
);

  lobm_pkg::dp_cmd_t  cmd;
  lobm_pkg::dp_stat_t stat;

  lobm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lobm_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .stat         (stat),
    .report       (report),
    .report_valid (report_valid)
  );

endmodule
